/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the cubic kernel block. They
// expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CBK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbk assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CBK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbk assertion failed");

`else

`define CBK_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CBK_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* src/cbk_pkg.sv */
// ----------------------------------------------------------------------------
// cbk_pkg
// Types and constants shared by the cubic (B, C) kernel evaluation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cbk_pkg;

    // Field widths.
    localparam int DIST_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int PARAM_W  = 16;
    localparam int CFG_IW   = 2;

    // Default number of fraction bits of the distance.
    localparam int FRAC_BITS_DEF = 13;

    // Datapath widths: coefficients and partial sums carry 16 fraction bits
    // and stay below 2^28 in magnitude; the absolute distance used by the
    // polynomials is below 2 in unsigned Q1.16.
    localparam int CW  = 30;
    localparam int XNW = 17;

    localparam int ONE_Q16 = 65536;
    localparam int TWO_Q16 = 131072;

    // Register indexes.
    localparam logic [CFG_IW-1:0] REG_BLUR_B = 2'd0;
    localparam logic [CFG_IW-1:0] REG_RING_C = 2'd1;

    localparam logic signed [PARAM_W-1:0] BLUR_B_RST = 16'sd1365;
    localparam logic signed [PARAM_W-1:0] RING_C_RST = 16'sd1365;

    // Coefficient constants, all six times the kernel value.
    localparam logic signed [CW-1:0] C_K0_BASE = CW'(6 * ONE_Q16);
    localparam logic signed [CW-1:0] C_K2_BASE = CW'(-18 * ONE_Q16);
    localparam logic signed [CW-1:0] C_K3_BASE = CW'(12 * ONE_Q16);
    localparam logic signed [CW-1:0] N2  = CW'(2);
    localparam logic signed [CW-1:0] N6  = CW'(6);
    localparam logic signed [CW-1:0] N8  = CW'(8);
    localparam logic signed [CW-1:0] N9  = CW'(9);
    localparam logic signed [CW-1:0] N12 = CW'(12);
    localparam logic signed [CW-1:0] N24 = CW'(24);
    localparam logic signed [CW-1:0] N30 = CW'(30);
    localparam logic signed [CW-1:0] N48 = CW'(48);

    // Final scaling: weight = floor((s + 12) / 24), done as a floor shift by
    // three, then a floor division by three on a biased, nonnegative value.
    localparam logic signed [CW-1:0] RND_BIAS = CW'(12);
    localparam int                   QBIAS    = 33554432;        // 2^25
    localparam logic signed [CW-1:0] DIV_OFS  = CW'(3 * QBIAS);
    localparam int                   VW       = 27;
    localparam int                   MW       = 28;
    localparam int                   DIV3_SH  = 28;
    localparam logic [MW-1:0]        DIV3_MUL = 28'd89478486;     // ceil(2^28 / 3)
    localparam int                   PW       = VW + MW;

    localparam logic signed [WEIGHT_W-1:0] W_MAX = 16'sh7FFF;
    localparam logic signed [WEIGHT_W-1:0] W_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [CW-1:0] k0;
        logic signed [CW-1:0] k2;
        logic signed [CW-1:0] k3;
        logic signed [CW-1:0] m0;
        logic signed [CW-1:0] m1;
        logic signed [CW-1:0] m2;
        logic signed [CW-1:0] m3;
    } t_coef;

endpackage

`default_nettype wire

/* src/cubic_bc_kernel_eval_core.sv */
// ----------------------------------------------------------------------------
// cubic_bc_kernel_eval_core
// Pipelined evaluator of the two-parameter (B, C) cubic resampling kernel.
//
//   Channel   Direction  Handshake                  Payload
//   dist      in         i_dist_valid/o_dist_stall  i_distance (Q3.13)
//   weight    out        o_weight_valid/i_weight_stall  o_weight (Q2.14), o_clipped
//   cfg       in         i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_dist_stall is low; each item passes
// through six register stages: front stage, three Horner multiplier stages,
// divide and saturate stages.
// Each stage holds its item while the stage after it is full and blocked, so
// bubbles close up and o_dist_stall rises only when every stage is full.
// Reset empties the pipeline and sets B and C to 1/3; configuration writes
// are always taken and apply to items accepted afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cubic_bc_kernel_eval_core
    import cbk_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_dist_valid,
    output logic                             o_dist_stall,
    input  wire logic signed [DIST_W-1:0]    i_distance,
    output logic                             o_weight_valid,
    input  wire logic                        i_weight_stall,
    output logic signed [WEIGHT_W-1:0]       o_weight,
    output logic                             o_clipped,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [CFG_IW-1:0]           i_cfg_index,
    input  wire logic signed [PARAM_W-1:0]   i_cfg_data
);

    t_coef                 coef;

    logic                  f_valid;
    logic [XNW-1:0]        f_xn;
    logic signed [CW-1:0]  f_a3, f_a2, f_a1, f_a0;

    logic                  h1_valid, h2_valid, h3_valid;
    logic signed [CW-1:0]  h1_acc, h2_acc, h3_acc;
    logic [XNW-1:0]        h1_xn, h2_xn, h3_xn;

    logic signed [CW-1:0]  r_h1_a1, r_h1_a0, r_h2_a0;

    logic                  rdy_f, rdy_h1, rdy_h2, rdy_h3, rdy_r;

    assign o_cfg_ready = 1'b1;

    cbk_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef)
    );

    // Ready chain from the output back to the input.
    assign rdy_h3 = !h3_valid || rdy_r;
    assign rdy_h2 = !h2_valid || rdy_h3;
    assign rdy_h1 = !h1_valid || rdy_h2;
    assign rdy_f  = !f_valid  || rdy_h1;
    assign o_dist_stall = !rdy_f;

    cbk_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (rdy_f),
        .i_valid    (i_dist_valid),
        .i_distance (i_distance),
        .i_coef     (coef),
        .o_valid    (f_valid),
        .o_xn       (f_xn),
        .o_a3       (f_a3),
        .o_a2       (f_a2),
        .o_a1       (f_a1),
        .o_a0       (f_a0)
    );

    cbk_horner u_h1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (rdy_h1),
        .i_valid (f_valid),
        .i_acc   (f_a3),
        .i_add   (f_a2),
        .i_xn    (f_xn),
        .o_valid (h1_valid),
        .o_acc   (h1_acc),
        .o_xn    (h1_xn)
    );

    cbk_horner u_h2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (rdy_h2),
        .i_valid (h1_valid),
        .i_acc   (h1_acc),
        .i_add   (r_h1_a1),
        .i_xn    (h1_xn),
        .o_valid (h2_valid),
        .o_acc   (h2_acc),
        .o_xn    (h2_xn)
    );

    cbk_horner u_h3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (rdy_h3),
        .i_valid (h2_valid),
        .i_acc   (h2_acc),
        .i_add   (r_h2_a0),
        .i_xn    (h2_xn),
        .o_valid (h3_valid),
        .o_acc   (h3_acc),
        .o_xn    (h3_xn)
    );

    // The lower coefficients ride alongside the Horner stages until used.
    always_ff @(posedge i_clk) begin
        if (rdy_h1 && f_valid) begin
            r_h1_a1 <= f_a1;
            r_h1_a0 <= f_a0;
        end
        if (rdy_h2 && h1_valid) begin
            r_h2_a0 <= r_h1_a0;
        end
    end

    cbk_round u_round (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (h3_valid),
        .i_sum     (h3_acc),
        .i_stall   (i_weight_stall),
        .o_ready   (rdy_r),
        .o_valid   (o_weight_valid),
        .o_weight  (o_weight),
        .o_clipped (o_clipped)
    );

    `CBK_ASSERT_IMP(a_stall_only_when_blocked, i_clk, i_rst_n, o_dist_stall, o_weight_valid && i_weight_stall)
    `CBK_ASSERT_IMP(a_full_when_stalled, i_clk, i_rst_n, o_dist_stall, f_valid && h1_valid && h2_valid && h3_valid)
    `CBK_ASSERT_NXT(a_h3_holds, i_clk, i_rst_n, h3_valid && !rdy_h3, h3_valid && $stable(h3_xn))

endmodule

`default_nettype wire

/* src/cbk_coef.sv */
// ----------------------------------------------------------------------------
// cbk_coef
// Holds the B and C registers and forms the seven polynomial coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module cbk_coef
    import cbk_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    input  wire logic [CFG_IW-1:0]           i_cfg_index,
    input  wire logic signed [PARAM_W-1:0]   i_cfg_data,
    output t_coef                            o_coef
);

    logic signed [PARAM_W-1:0] r_blur_b, n_blur_b;
    logic signed [PARAM_W-1:0] r_ring_c, n_ring_c;
    logic signed [CW-1:0]      bq;
    logic signed [CW-1:0]      cq;

    always_comb begin
        n_blur_b = r_blur_b;
        n_ring_c = r_ring_c;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BLUR_B: n_blur_b = i_cfg_data;
                REG_RING_C: n_ring_c = i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blur_b <= BLUR_B_RST;
            r_ring_c <= RING_C_RST;
        end else begin
            r_blur_b <= n_blur_b;
            r_ring_c <= n_ring_c;
        end
    end

    // Q4.12 to 16 fraction bits.
    assign bq = {{(CW - PARAM_W - 4){r_blur_b[PARAM_W-1]}}, r_blur_b, 4'b0000};
    assign cq = {{(CW - PARAM_W - 4){r_ring_c[PARAM_W-1]}}, r_ring_c, 4'b0000};

    always_comb begin
        o_coef.k0 = C_K0_BASE - N2 * bq;
        o_coef.k2 = C_K2_BASE + N12 * bq + N6 * cq;
        o_coef.k3 = C_K3_BASE - N9 * bq - N6 * cq;
        o_coef.m0 = N8 * bq + N24 * cq;
        o_coef.m1 = -(N12 * bq) - N48 * cq;
        o_coef.m2 = N6 * bq + N30 * cq;
        o_coef.m3 = -bq - N6 * cq;
    end

endmodule

`default_nettype wire

/* src/cbk_front.sv */
// ----------------------------------------------------------------------------
// cbk_front
// First pipeline stage: absolute distance, scaling to Q1.16, segment choice
// and coefficient selection.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cbk_front
    import cbk_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic                      i_valid,
    input  wire logic [DIST_W-1:0]         i_distance,
    input  t_coef                          i_coef,
    output logic                           o_valid,
    output logic [XNW-1:0]                 o_xn,
    output logic signed [CW-1:0]           o_a3,
    output logic signed [CW-1:0]           o_a2,
    output logic signed [CW-1:0]           o_a1,
    output logic signed [CW-1:0]           o_a0
);

    logic [DIST_W:0]       mag;
    logic [31:0]           xw;
    logic                  inner;
    logic                  near;
    logic [XNW-1:0]        n_xn;
    logic signed [CW-1:0]  n_a3, n_a2, n_a1, n_a0;
    logic                  r_valid;

    // The most negative distance still gets its full magnitude of 2^15.
    assign mag = i_distance[DIST_W-1] ? ((DIST_W+1)'(ONE_Q16) - {1'b0, i_distance})
                                      : {1'b0, i_distance};

    if (FRAC_BITS <= 16) begin : g_shl
        localparam int SH = 16 - FRAC_BITS;
        assign xw = 32'(mag) << SH;
    end else begin : g_shr
        localparam int SH = FRAC_BITS - 16;
        assign xw = 32'(mag >> SH);
    end

    assign inner = xw < 32'(ONE_Q16);
    assign near  = xw < 32'(TWO_Q16);

    always_comb begin
        n_xn = '0;
        n_a3 = '0;
        n_a2 = '0;
        n_a1 = '0;
        n_a0 = '0;
        if (inner) begin
            n_xn = xw[XNW-1:0];
            n_a3 = i_coef.k3;
            n_a2 = i_coef.k2;
            n_a0 = i_coef.k0;
        end else if (near) begin
            n_xn = xw[XNW-1:0];
            n_a3 = i_coef.m3;
            n_a2 = i_coef.m2;
            n_a1 = i_coef.m1;
            n_a0 = i_coef.m0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            o_xn <= n_xn;
            o_a3 <= n_a3;
            o_a2 <= n_a2;
            o_a1 <= n_a1;
            o_a0 <= n_a0;
        end
    end

    assign o_valid = r_valid;

    // The inner cubic has no linear term, and far items carry all zeros.
    `CBK_ASSERT_IMP(a_inner_no_linear, i_clk, i_rst_n, r_valid && !o_xn[XNW-1], o_a1 == '0)

endmodule

`default_nettype wire

/* src/cbk_horner.sv */
// ----------------------------------------------------------------------------
// cbk_horner
// One Horner step as a pipeline stage: acc * x in Q16, floored, plus addend.
// ----------------------------------------------------------------------------
`default_nettype none

module cbk_horner
    import cbk_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic                      i_valid,
    input  wire logic signed [CW-1:0]      i_acc,
    input  wire logic signed [CW-1:0]      i_add,
    input  wire logic [XNW-1:0]            i_xn,
    output logic                           o_valid,
    output logic signed [CW-1:0]           o_acc,
    output logic [XNW-1:0]                 o_xn
);

    logic signed [CW+XNW:0] prod;
    logic signed [CW-1:0]   n_acc;
    logic                   r_valid;

    assign prod  = i_acc * $signed({1'b0, i_xn});
    // Dropping the 16 low bits of the two's complement product floors it.
    assign n_acc = i_add + $signed(prod[CW+15:16]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            o_acc <= n_acc;
            o_xn  <= i_xn;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* src/cbk_round.sv */
// ----------------------------------------------------------------------------
// cbk_round
// Last two stages: divide the six-times sum by 24 with round half up, then
// saturate to Q2.14 in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cbk_round
    import cbk_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic signed [CW-1:0]        i_sum,
    input  wire logic                        i_stall,
    output logic                             o_ready,
    output logic                             o_valid,
    output logic signed [WEIGHT_W-1:0]       o_weight,
    output logic                             o_clipped
);

    logic signed [CW-1:0]       biased;
    logic [PW-1:0]              n_prod;
    logic [PW-1:0]              r_prod;
    logic                       r_e_valid;
    logic                       r_valid;
    logic                       rdy_e;
    logic                       rdy_f;
    logic signed [VW-1:0]       wq;
    logic signed [WEIGHT_W-1:0] n_weight;
    logic                       n_clipped;

    assign rdy_f = !r_valid || !i_stall;
    assign rdy_e = !r_e_valid || rdy_f;

    // Floor shift by eight's worth, then offset so the divide by three sees a
    // nonnegative value below 2^27.
    assign biased = ((i_sum + RND_BIAS) >>> 3) + DIV_OFS;
    assign n_prod = PW'(biased[VW-1:0]) * PW'(DIV3_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (rdy_e) begin
                r_e_valid <= i_valid;
            end
            if (rdy_f) begin
                r_valid <= r_e_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_e && i_valid) begin
            r_prod <= n_prod;
        end
        if (rdy_f && r_e_valid) begin
            o_weight  <= n_weight;
            o_clipped <= n_clipped;
        end
    end

    assign wq = $signed(r_prod[PW-1:DIV3_SH]) - VW'(QBIAS);

    always_comb begin
        n_weight  = wq[WEIGHT_W-1:0];
        n_clipped = 1'b0;
        if (wq > VW'(W_MAX)) begin
            n_weight  = W_MAX;
            n_clipped = 1'b1;
        end else if (wq < VW'(W_MIN)) begin
            n_weight  = W_MIN;
            n_clipped = 1'b1;
        end
    end

    assign o_ready = rdy_e;
    assign o_valid = r_valid;

    `CBK_ASSERT_IMP(a_clip_at_rail, i_clk, i_rst_n, r_valid && o_clipped, o_weight == W_MAX || o_weight == W_MIN)
    `CBK_ASSERT_NXT(a_mid_holds, i_clk, i_rst_n, r_e_valid && !rdy_f, r_e_valid)

endmodule

`default_nettype wire

/* tb/kernel_weight_checker.sv */
// ----------------------------------------------------------------------------
// kernel_weight_checker
// Watches the distance, weight and configuration channels of the cubic (B, C)
// kernel core. It keeps its own copy of B and C, computes the weight of every
// accepted distance and compares each delivered weight, in order, with it.
// ----------------------------------------------------------------------------
module kernel_weight_checker
    import cbk_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_dist_valid,
    input  logic                        i_dist_stall,
    input  logic signed [DIST_W-1:0]    i_distance,
    input  logic                        i_weight_valid,
    input  logic                        i_weight_stall,
    input  logic signed [WEIGHT_W-1:0]  i_weight,
    input  logic                        i_clipped,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [CFG_IW-1:0]           i_cfg_index,
    input  logic signed [PARAM_W-1:0]   i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_saturated
);

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic                       clipped;
    } t_weight;

    t_weight expected_weights [$];
    logic signed [PARAM_W-1:0] blur_b = BLUR_B_RST;
    logic signed [PARAM_W-1:0] ring_c = RING_C_RST;
    t_weight predicted;
    t_weight oldest;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_saturated  = 0;
    end

    // Product of a Q16 value and the Q16 distance, floored back to Q16.
    function automatic longint q16_mul(input longint a, input longint x);
        return (a * x) >>> 16;
    endfunction

    function automatic t_weight kernel_weight(input logic signed [DIST_W-1:0] dist_in,
                                              input logic signed [PARAM_W-1:0] b,
                                              input logic signed [PARAM_W-1:0] c);
        longint  mag, xn, bq, cq, s, t, q;
        longint  k0, k2, k3, m0, m1, m2, m3;
        int      up_sh;
        t_weight r;
        mag = (dist_in < 0) ? -longint'(dist_in) : longint'(dist_in);
        up_sh = 16 - FRAC_BITS;
        if (up_sh >= 0) begin
            xn = mag << up_sh;
        end else begin
            xn = mag >> (-up_sh);
        end
        bq = longint'(b) * 16;
        cq = longint'(c) * 16;
        if (xn < ONE_Q16) begin
            k0 = 6 * longint'(ONE_Q16) - 2 * bq;
            k2 = -18 * longint'(ONE_Q16) + 12 * bq + 6 * cq;
            k3 = 12 * longint'(ONE_Q16) - 9 * bq - 6 * cq;
            t = k2 + q16_mul(k3, xn);
            t = q16_mul(t, xn);
            t = q16_mul(t, xn);
            s = k0 + t;
        end else if (xn < TWO_Q16) begin
            m0 = 8 * bq + 24 * cq;
            m1 = -12 * bq - 48 * cq;
            m2 = 6 * bq + 30 * cq;
            m3 = -bq - 6 * cq;
            t = m2 + q16_mul(m3, xn);
            t = m1 + q16_mul(t, xn);
            s = m0 + q16_mul(t, xn);
        end else begin
            s = 0;
        end
        // The sum is six times the weight with 16 fraction bits; dividing by
        // 24 with a floor and a bias of 12 rounds half up to Q2.14.
        q = (s + 12) / 24;
        if (((s + 12) % 24) != 0 && (s + 12) < 0) begin
            q = q - 1;
        end
        r.clipped = 1'b0;
        if (q > 32767) begin
            r.weight  = W_MAX;
            r.clipped = 1'b1;
        end else if (q < -32768) begin
            r.weight  = W_MIN;
            r.clipped = 1'b1;
        end else begin
            r.weight = WEIGHT_W'(q);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_weights.delete();
            blur_b = BLUR_B_RST;
            ring_c = RING_C_RST;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_BLUR_B: blur_b = i_cfg_data;
                    REG_RING_C: ring_c = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_dist_valid && !i_dist_stall) begin
                predicted = kernel_weight(i_distance, blur_b, ring_c);
                expected_weights.push_back(predicted);
            end
            if (i_weight_valid && !i_weight_stall) begin
                if (expected_weights.size() == 0) begin
                    $display("%0t: weight %0d delivered with no distance outstanding",
                             $time, i_weight);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    oldest = expected_weights.pop_front();
                    o_checked = o_checked + 1;
                    if (oldest.clipped) begin
                        o_saturated = o_saturated + 1;
                    end
                    if (i_weight !== oldest.weight) begin
                        $display("%0t: weight mismatch: expected %0d, actual %0d",
                                 $time, oldest.weight, i_weight);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_clipped !== oldest.clipped) begin
                        $display("%0t: clipped mismatch: expected %0b, actual %0b",
                                 $time, oldest.clipped, i_clipped);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_weights.size();
    end

endmodule

/* tb/tb_cubic_bc_kernel_eval_core.sv */
// ----------------------------------------------------------------------------
// tb_cubic_bc_kernel_eval_core
// Drives distances through the cubic (B, C) kernel core under a series of
// kernel settings, from the reset values to the extremes of both registers,
// with bursty input and a stalling output. A checker beside the core predicts
// and compares every weight; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_cubic_bc_kernel_eval_core;
    import cbk_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_CYCLES = 64;
    localparam int HOLD_BURST  = 30;

    // Indexes that decode to no register; writes to them must be dropped.
    localparam logic [CFG_IW-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IW-1:0] REG_SPARE_3 = 2'd3;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        dist_valid;
    logic                        dist_stall;
    logic signed [DIST_W-1:0]    distance;
    logic                        weight_valid;
    logic                        weight_stall;
    logic signed [WEIGHT_W-1:0]  weight;
    logic                        clipped;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IW-1:0]           cfg_index;
    logic signed [PARAM_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int checked;
    int saturated;
    int items_sent = 0;
    int settings_run = 0;
    bit hold_request = 1'b0;

    // Distances around zero, one, two and the ends of the field.
    logic signed [DIST_W-1:0] corner_points [$] = '{
        16'sd0, 16'sd1, -16'sd1, 16'sd4096, -16'sd4096, 16'sd8191, -16'sd8191,
        16'sd8192, -16'sd8192, 16'sd8193, 16'sd12288, -16'sd12288, 16'sd16383,
        -16'sd16383, 16'sd16384, -16'sd16384, 16'sd16385, 16'sd24576,
        16'sd32767, -16'sd32767, -16'sd32768, 16'sd2730
    };

    cubic_bc_kernel_eval_core #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_dist_valid   (dist_valid),
        .o_dist_stall   (dist_stall),
        .i_distance     (distance),
        .o_weight_valid (weight_valid),
        .i_weight_stall (weight_stall),
        .o_weight       (weight),
        .o_clipped      (clipped),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    kernel_weight_checker #(
        .FRAC_BITS(FRAC)
    ) checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_dist_valid   (dist_valid),
        .i_dist_stall   (dist_stall),
        .i_distance     (distance),
        .i_weight_valid (weight_valid),
        .i_weight_stall (weight_stall),
        .i_weight       (weight),
        .i_clipped      (clipped),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_saturated    (saturated)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Output side: randomly chosen stall patterns that each run for a random span,
    // and a long hold-off whenever the stimulus asks for one.
    initial begin
        int mode;
        int left;
        int period;
        int tick;
        mode = 0;
        left = 0;
        period = 1;
        tick = 0;
        weight_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                weight_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end else begin
                if (left == 0) begin
                    mode   = $urandom_range(0, 3);
                    left   = $urandom_range(50, 300);
                    period = $urandom_range(1, 5);
                end
                left = left - 1;
                tick = tick + 1;
                case (mode)
                    0: weight_stall = 1'b0;
                    1: weight_stall = ($urandom_range(0, 3) == 0);
                    2: weight_stall = ($urandom_range(0, 3) != 0);
                    default: weight_stall = ((tick / period) % 2 == 1);
                endcase
            end
        end
    end

    function automatic logic signed [DIST_W-1:0] pick_distance();
        logic signed [DIST_W-1:0] d;
        case ($urandom_range(0, 7))
            0: d = corner_points[$urandom_range(0, corner_points.size() - 1)];
            1, 2: d = DIST_W'($urandom);
            default: begin
                // Most items land inside the support, where the cubics live.
                d = DIST_W'($urandom_range(0, 16384));
                if ($urandom_range(0, 1) == 1) begin
                    d = -d;
                end
            end
        endcase
        return d;
    endfunction

    task automatic offer_distance(input logic signed [DIST_W-1:0] d);
        @(negedge clk);
        dist_valid = 1'b1;
        distance   = d;
        @(posedge clk);
        while (dist_stall) @(posedge clk);
        items_sent = items_sent + 1;
    endtask

    task automatic idle_sender(input int n);
        @(negedge clk);
        dist_valid = 1'b0;
        distance   = DIST_W'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_all_weights();
        @(negedge clk);
        dist_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IW-1:0] idx,
                                  input logic signed [PARAM_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Registers change only with the pipeline empty.
    task automatic load_kernel(input logic signed [PARAM_W-1:0] b,
                               input logic signed [PARAM_W-1:0] c);
        wait_all_weights();
        write_register(REG_BLUR_B, b);
        write_register(REG_RING_C, c);
        write_register(($urandom_range(0, 1) == 1) ? REG_SPARE_2 : REG_SPARE_3,
                       PARAM_W'($urandom));
        settings_run = settings_run + 1;
    endtask

    task automatic run_distances(input int n, input bit with_hold);
        int sent;
        int len;
        sent = 0;
        if (with_hold) begin
            // Keep offering while the output is held so the pipeline fills.
            hold_request = 1'b1;
            repeat (HOLD_BURST) offer_distance(pick_distance());
            sent = HOLD_BURST;
        end
        while (sent < n) begin
            len = $urandom_range(1, 20);
            repeat (len) offer_distance(pick_distance());
            sent = sent + len;
            case ($urandom_range(0, 9))
                0: wait_all_weights();
                1, 2, 3: ;
                default: idle_sender($urandom_range(1, 8));
            endcase
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        dist_valid = 1'b0;
        distance   = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_BLUR_B;
        cfg_data   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset values first: the corner distances, then random ones.
        settings_run = 1;
        foreach (corner_points[i]) offer_distance(corner_points[i]);
        run_distances(PHASE_ITEMS, 1'b1);

        load_kernel(16'sh7FFF, 16'sh7FFF);
        run_distances(PHASE_ITEMS, 1'b0);
        load_kernel(16'sh8000, 16'sh8000);
        run_distances(PHASE_ITEMS, 1'b1);
        load_kernel(16'sh7FFF, 16'sh8000);
        run_distances(PHASE_ITEMS, 1'b0);
        load_kernel(16'sh8000, 16'sh7FFF);
        run_distances(PHASE_ITEMS, 1'b0);
        load_kernel(16'sd0, 16'sd0);
        run_distances(PHASE_ITEMS, 1'b0);
        // Cubic B-spline, then Catmull-Rom.
        load_kernel(16'sd4096, 16'sd0);
        run_distances(PHASE_ITEMS, 1'b1);
        load_kernel(16'sd0, 16'sd2048);
        run_distances(PHASE_ITEMS, 1'b0);
        repeat (3) begin
            load_kernel(PARAM_W'($urandom), PARAM_W'($urandom));
            run_distances(PHASE_ITEMS, 1'b0);
        end
        load_kernel(BLUR_B_RST, RING_C_RST);
        run_distances(PHASE_ITEMS, 1'b1);

        wait_all_weights();
        repeat (20) @(negedge clk);

        $display("Ran %0d distances under %0d kernel settings.", items_sent, settings_run);
        $display("Compared %0d weights, %0d of them saturated.", checked, saturated);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* cubic_bc_kernel_eval_core.f */
+incdir+src
src/cbk_pkg.sv
src/cbk_coef.sv
src/cbk_front.sv
src/cbk_horner.sv
src/cbk_round.sv
src/cubic_bc_kernel_eval_core.sv
tb/kernel_weight_checker.sv
tb/tb_cubic_bc_kernel_eval_core.sv
